### src/cubic_hermite_resampler_defines.svh
// assertion macros shared by the resampler rtl
`ifndef CUBIC_HERMITE_RESAMPLER_DEFINES_SVH
`define CUBIC_HERMITE_RESAMPLER_DEFINES_SVH

// same-cycle implication, checked on every clock while out of reset
`define CHR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clock while out of reset
`define CHR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/chr_pkg.sv
// shared types and constants for the cubic hermite resampler
`timescale 1ns / 1ps
`default_nettype none

package chr_pkg;

  // fraction bits of the phase accumulator and the phase step
  localparam int FRAC_BITS = 16;

  // width of the phase step register
  localparam int STEP_W = 19;

  // reset value of the phase step, 1.0 in q16
  localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 19'd65536;

  // most results one source frame can produce
  localparam int MAX_OUT = 64;

  // register word indexes
  localparam logic REG_PHASE_STEP = 1'b0;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_SQ_WAIT,
    ST_CUBE,
    ST_CUBE_WAIT,
    ST_COEF,
    ST_CHAN,
    ST_EMIT,
    ST_FIN
  } chr_state_t;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul;    // issue a product this cycle
    logic first;  // start a new sum from the init value
  } chr_mac_ctrl_t;

endpackage

`default_nettype wire

### src/chr_mac.sv
// shared multiply-accumulate unit: registered product, then accumulate
`timescale 1ns / 1ps
`default_nettype none

module chr_mac import chr_pkg::*; #(
  parameter int A_W   = 26,
  parameter int B_W   = 19,
  parameter int ACC_W = 47
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire chr_mac_ctrl_t           ctrl,
  input  wire logic signed [A_W-1:0]   a,
  input  wire logic signed [B_W-1:0]   b,
  input  wire logic signed [ACC_W-1:0] init,
  output logic signed [ACC_W-1:0]      acc
);

  logic signed [A_W+B_W-1:0] prod;
  logic signed [ACC_W-1:0]   init_d;
  logic                      add_d;
  logic                      first_d;
  logic signed [ACC_W-1:0]   base;

  // product stage
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod   <= a * b;
      init_d <= init;
    end
  end

  // control is registered alongside the product, so the two line up at the accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      add_d   <= 1'b0;
      first_d <= 1'b0;
    end else begin
      add_d   <= ctrl.mul;
      first_d <= ctrl.first;
    end
  end

  // accumulate stage
  assign base = first_d ? init_d : acc;

  always_ff @(posedge clk) begin
    if (add_d) begin
      acc <= base + ACC_W'(prod);
    end
  end

endmodule

`default_nettype wire

### src/cubic_hermite_resampler.sv
// cubic hermite resampler top level: history, phase sequencer, output register
// Stereo sample-rate converter, one source frame in, zero or more frames out.
// Input channel: in_left, in_right, silent with in_valid / in_stall. A request is
// taken when in_valid is high and in_stall low; in_stall stays high while a
// frame is being worked on.
// Output channel: out_left, out_right, past_end, last_of_run with out_valid /
// out_stall. last_of_run marks the final result caused by one input frame.
// Each result goes through one shared multiplier under a small sequencer:
// two products for the cubic weights, then three per channel. A frame holds
// in_stall high while its results are made, also when it yields no result,
// and the sequencer passes through idle before the next request can be taken;
// on average about 65536 / phase_step results per frame (at most 64 results).
// Per result the states run ST_CHECK, ST_SQ_WAIT, ST_CUBE, ST_CUBE_WAIT,
// ST_COEF, ST_CHAN and ST_EMIT; ST_PREP comes first and ST_FIN last per frame.
// When the receiver stalls, the finished result waits in the output register
// and the sequencer holds before loading the next one; a new input request is
// taken while the last result of a frame still waits.
// phase_step must be written over the apb-style port at byte address 0
// while idle; the block does not enforce this. Reset clears the history,
// phase and end flag and sets phase_step to 1.0; in_stall is held high during reset.
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_hermite_resampler_defines.svh"

module cubic_hermite_resampler import chr_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // source frames
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right,
  input  wire logic                          silent,
  // interpolated frames
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_left,
  output logic signed [SAMPLE_BITS-1:0]      out_right,
  output logic                               past_end,
  output logic                               last_of_run
);

  localparam int F       = FRAC_BITS;
  localparam int S       = SAMPLE_BITS;
  localparam int PHASE_W = ((F > STEP_W) ? F : STEP_W) + 1;
  localparam int A_W     = ((S + 2) > (F + 2)) ? (S + 2) : (F + 2);
  localparam int B_W     = F + 3;
  localparam int ACC_W   = A_W + B_W + 2;
  localparam int RES_W   = ACC_W - F;
  localparam int NCNT_W  = $clog2(MAX_OUT + 1);

  localparam logic [PHASE_W-1:0] ONE_UNIT  = PHASE_W'(1) << F;
  localparam logic [PHASE_W-1:0] PHASE_LIM = PHASE_W'(1) << STEP_W;
  localparam logic [STEP_W-1:0]  STEP_MIN  = STEP_W'(1) << (F - 6);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (F - 1);
  localparam logic signed [ACC_W-1:0] ROUND_ONE  = ACC_W'(1) << F;

  chr_state_t state, state_next;

  logic [STEP_W-1:0]         phase_step;
  logic [STEP_W-1:0]         step_q;
  logic [PHASE_W-1:0]        phase;
  logic                      ended;
  logic signed [S-1:0]       hist_l [4];
  logic signed [S-1:0]       hist_r [4];
  logic signed [A_W-1:0]     dif [2][3];
  logic [F:0]                m2;
  logic signed [B_W-1:0]     h01, h10, h11;
  logic signed [S-1:0]       res_l;
  logic signed [S-1:0]       res_r;
  logic [NCNT_W-1:0]         run_cnt;
  logic                      ch;
  logic [2:0]                k;

  chr_mac_ctrl_t             mac_ctrl;
  logic signed [A_W-1:0]     mac_a;
  logic signed [B_W-1:0]     mac_b;
  logic signed [ACC_W-1:0]   mac_init;
  logic signed [ACC_W-1:0]   acc;

  logic                      in_take;
  logic                      cfg_wr;
  logic [F-1:0]              m;
  logic [F:0]                acc_hi;
  logic [PHASE_W-1:0]        phase_adv;
  logic                      emit_load;
  logic                      emit_last;
  logic signed [B_W-1:0]     h11_c, z_c, h01_c, h10_c;
  logic signed [S-1:0]       y1_sel;
  logic signed [RES_W-1:0]   res_sum;
  logic signed [S-1:0]       res_sat;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= PHASE_STEP_RESET;
    end else if (cfg_wr && (paddr[2] == REG_PHASE_STEP)) begin
      phase_step <= pwdata[STEP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PHASE_STEP) ? 32'(phase_step) : 32'd0;

  // handshake
  assign in_stall  = rst || (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;

  // common datapath terms
  assign m         = phase[F-1:0];
  assign acc_hi    = acc[F +: F+1];
  assign phase_adv = phase + PHASE_W'(step_q);
  assign emit_last = (phase_adv >= ONE_UNIT) || (run_cnt == NCNT_W'(MAX_OUT - 1));
  assign emit_load = (state == ST_EMIT) && !(out_valid && out_stall);

  // hermite weights from m, m^2 and m^3
  always_comb begin
    h11_c = $signed(B_W'(acc_hi)) - $signed(B_W'(m2));
    z_c   = $signed(B_W'(m2)) - h11_c;
    h01_c = z_c - h11_c;
    h10_c = $signed(B_W'(m)) - z_c;
  end

  // round, add the base sample and saturate
  always_comb begin
    y1_sel  = ch ? hist_r[1] : hist_l[1];
    res_sum = RES_W'(y1_sel) + RES_W'($signed(acc[ACC_W-1:F+1]));
    if (!res_sum[RES_W-1] && (|res_sum[RES_W-2:S-1])) begin
      res_sat = {1'b0, {(S-1){1'b1}}};
    end else if (res_sum[RES_W-1] && !(&res_sum[RES_W-2:S-1])) begin
      res_sat = {1'b1, {(S-1){1'b0}}};
    end else begin
      res_sat = res_sum[S-1:0];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and shared unit control
  always_comb begin
    state_next     = state;
    mac_ctrl.mul   = 1'b0;
    mac_ctrl.first = 1'b0;
    mac_a          = '0;
    mac_b          = '0;
    mac_init       = ROUND_ONE;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (phase < ONE_UNIT) begin
          mac_ctrl.mul   = 1'b1;
          mac_ctrl.first = 1'b1;
          mac_a          = $signed(A_W'(m));
          mac_b          = $signed(B_W'(m));
          mac_init       = ROUND_HALF;
          state_next     = ST_SQ_WAIT;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_SQ_WAIT: begin
        state_next = ST_CUBE;
      end
      ST_CUBE: begin
        mac_ctrl.mul   = 1'b1;
        mac_ctrl.first = 1'b1;
        mac_a          = $signed(A_W'(acc_hi));
        mac_b          = $signed(B_W'(m));
        mac_init       = ROUND_HALF;
        state_next     = ST_CUBE_WAIT;
      end
      ST_CUBE_WAIT: begin
        state_next = ST_COEF;
      end
      ST_COEF: begin
        state_next = ST_CHAN;
      end
      ST_CHAN: begin
        case (k)
          3'd0: begin
            mac_ctrl.mul   = 1'b1;
            mac_ctrl.first = 1'b1;
            mac_a          = dif[ch][0];
            mac_b          = h01;
          end
          3'd1: begin
            mac_ctrl.mul = 1'b1;
            mac_a        = dif[ch][1];
            mac_b        = h10;
          end
          3'd2: begin
            mac_ctrl.mul = 1'b1;
            mac_a        = dif[ch][2];
            mac_b        = h11;
          end
          default: begin
            mac_ctrl.mul = 1'b0;
          end
        endcase
        if ((k == 3'd4) && ch) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_next = emit_last ? ST_FIN : ST_CHECK;
        end
      end
      ST_FIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // shared multiply-accumulate unit
  chr_mac #(
    .A_W   (A_W),
    .B_W   (B_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .init (mac_init),
    .acc  (acc)
  );

  // history, phase and end flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        hist_l[i] <= '0;
        hist_r[i] <= '0;
      end
      phase  <= '0;
      ended  <= 1'b0;
      step_q <= PHASE_STEP_RESET;
    end else begin
      if (in_take) begin
        for (int i = 0; i < 3; i++) begin
          hist_l[i] <= hist_l[i+1];
          hist_r[i] <= hist_r[i+1];
        end
        hist_l[3] <= in_left;
        hist_r[3] <= in_right;
        if (silent) begin
          ended <= 1'b1;
        end
        step_q <= (phase_step < STEP_MIN) ? STEP_MIN : phase_step;
      end
      if (emit_load) begin
        phase <= phase_adv;
      end
      if (state == ST_FIN) begin
        phase <= (phase >= ONE_UNIT) ? (phase - ONE_UNIT) : '0;
      end
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
      ch      <= 1'b0;
      k       <= '0;
    end else begin
      if (state == ST_FIN) begin
        run_cnt <= '0;
      end else if (emit_load) begin
        run_cnt <= run_cnt + NCNT_W'(1);
      end
      if (state == ST_COEF) begin
        ch <= 1'b0;
        k  <= '0;
      end else if (state == ST_CHAN) begin
        if (k == 3'd4) begin
          ch <= 1'b1;
          k  <= '0;
        end else begin
          k <= k + 3'd1;
        end
      end
    end
  end

  // differences of the history, fixed for the whole run
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      dif[0][0] <= (A_W'(hist_l[2]) - A_W'(hist_l[1])) <<< 1;
      dif[0][1] <= A_W'(hist_l[2]) - A_W'(hist_l[0]);
      dif[0][2] <= A_W'(hist_l[3]) - A_W'(hist_l[1]);
      dif[1][0] <= (A_W'(hist_r[2]) - A_W'(hist_r[1])) <<< 1;
      dif[1][1] <= A_W'(hist_r[2]) - A_W'(hist_r[0]);
      dif[1][2] <= A_W'(hist_r[3]) - A_W'(hist_r[1]);
    end
  end

  // cubic weights
  always_ff @(posedge clk) begin
    if (state == ST_CUBE) begin
      m2 <= acc_hi;
    end
    if (state == ST_COEF) begin
      h01 <= h01_c;
      h10 <= h10_c;
      h11 <= h11_c;
    end
  end

  // channel results wait here until the output register is free
  always_ff @(posedge clk) begin
    if ((state == ST_CHAN) && (k == 3'd4)) begin
      if (ch) begin
        res_r <= res_sat;
      end else begin
        res_l <= res_sat;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_left    <= res_l;
      out_right   <= res_r;
      past_end    <= ended;
      last_of_run <= emit_last;
    end
  end

  // checks
  `CHR_ASSERT_IMP(a_idle_clean, state == ST_IDLE,
    (run_cnt == '0) && (phase < PHASE_LIM), "idle with a stale run count or phase")
  `CHR_ASSERT_IMP(a_run_bound, state != ST_IDLE,
    run_cnt <= NCNT_W'(MAX_OUT), "run count past its limit")
  `CHR_ASSERT_NXT(a_hist_shift, in_take,
    (hist_l[3] == $past(in_left)) && (hist_r[3] == $past(in_right)) &&
    (hist_l[2] == $past(hist_l[3])), "history did not shift on a request")
  `CHR_ASSERT_NXT(a_last_ends_run, emit_load && emit_last,
    state == ST_FIN, "last result did not close the run")

endmodule

`default_nettype wire
